[design/gbn_pkg.sv]
// Shared types and constants for the go-back-n sender window.
package gbn_pkg;

  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 32;
  localparam int KIND_W       = 2;
  localparam int TIMER_W      = 2;
  localparam int CMD_W        = 2;

  localparam logic [SEQ_W-1:0] WINDOW_SIZE_RESET = SEQ_W'(4);

  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SENT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

  localparam logic [TIMER_W-1:0] TIMER_LEAVE   = 2'd0;
  localparam logic [TIMER_W-1:0] TIMER_STOP    = 2'd1;
  localparam logic [TIMER_W-1:0] TIMER_RESTART = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_number;
    logic                    ack_checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [SEQ_W-1:0]        seq_number;
    logic [PAYLOAD_BITS-1:0] packet_payload;
    logic [TIMER_W-1:0]      timer_action;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic start_replay;
    logic rd;
    logic emit;
  } gbn_cmd_t;

  typedef struct packed {
    logic replay_needed;
    logic rep_last;
    logic out_free;
  } gbn_status_t;

endpackage

[design/gbn_ctrl.sv]
// Controller state machine that sequences accepts and timeout replays.
module gbn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gbn_pkg::gbn_status_t status,
  output gbn_pkg::gbn_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_stall = !((state_r == ST_IDLE) && status.out_free);
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept && status.replay_needed) begin
          cmd.start_replay = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = status.rep_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/gbn_dp.sv]
// Datapath holding the window pointers, the payload memory and the result register.
module gbn_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gbn_pkg::in_item_t                    in_data,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [gbn_pkg::SEQ_W-1:0]            cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gbn_pkg::out_item_t                   out_data,
  input  gbn_pkg::gbn_cmd_t                    cmd,
  output gbn_pkg::gbn_status_t                 status
);

  logic [gbn_pkg::SEQ_W-1:0]        window_size_r;
  logic [gbn_pkg::SEQ_W-1:0]        base_r;
  logic [gbn_pkg::SEQ_W-1:0]        base_nxt;
  logic [gbn_pkg::SEQ_W-1:0]        next_r;
  logic [gbn_pkg::SEQ_W-1:0]        next_nxt;
  logic [gbn_pkg::SEQ_W-1:0]        ptr_r;
  logic [gbn_pkg::SEQ_W-1:0]        rem_r;
  logic                             first_r;
  logic                             out_valid_r;
  gbn_pkg::out_item_t               out_data_r;
  gbn_pkg::out_item_t               result;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] rd_data_r;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] mem [gbn_pkg::SEQ_SPACE];
  logic                             mem_we;
  logic [gbn_pkg::SEQ_W-1:0]        count;
  logic [gbn_pkg::SEQ_W-1:0]        offset;
  logic [gbn_pkg::SEQ_W-1:0]        ack_next;
  logic [gbn_pkg::SEQ_W-1:0]        left_after_ack;

  assign count          = next_r - base_r;
  assign offset         = in_data.ack_number - base_r;
  assign ack_next       = in_data.ack_number + gbn_pkg::SEQ_W'(1);
  assign left_after_ack = next_r - ack_next;

  assign status.out_free      = !out_valid_r || !out_stall;
  assign status.replay_needed = (in_data.command == gbn_pkg::CMD_TIMEOUT) && (count != '0);
  assign status.rep_last      = (rem_r == gbn_pkg::SEQ_W'(1));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    result = '0;
    result.last = 1'b1;
    result.kind = gbn_pkg::KIND_NONE;
    base_nxt = base_r;
    next_nxt = next_r;
    mem_we = 1'b0;
    case (in_data.command)
      gbn_pkg::CMD_SEND: begin
        if (count >= window_size_r) begin
          result.kind = gbn_pkg::KIND_REFUSED;
        end else begin
          mem_we = cmd.accept;
          next_nxt = next_r + gbn_pkg::SEQ_W'(1);
          result.kind = gbn_pkg::KIND_SENT;
          result.seq_number = next_r;
          result.packet_payload = in_data.payload;
          result.timer_action = (count == '0) ? gbn_pkg::TIMER_RESTART
                                              : gbn_pkg::TIMER_LEAVE;
        end
      end
      gbn_pkg::CMD_ACK: begin
        if (in_data.ack_checksum_ok && (count != '0) && (offset < count)) begin
          base_nxt = ack_next;
          result.timer_action = (left_after_ack == '0) ? gbn_pkg::TIMER_STOP
                                                       : gbn_pkg::TIMER_RESTART;
        end
      end
      gbn_pkg::CMD_TIMEOUT: begin
        result.timer_action = gbn_pkg::TIMER_RESTART;
      end
      default: begin
        result.timer_action = gbn_pkg::TIMER_LEAVE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= gbn_pkg::WINDOW_SIZE_RESET;
      base_r        <= '0;
      next_r        <= '0;
      out_valid_r   <= 1'b0;
      ptr_r         <= '0;
      rem_r         <= '0;
      first_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_size_r <= cfg_data;
      end
      if (cmd.accept) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
      end
      if (cmd.start_replay) begin
        ptr_r   <= base_r;
        rem_r   <= count;
        first_r <= 1'b1;
      end else if (cmd.emit) begin
        ptr_r   <= ptr_r + gbn_pkg::SEQ_W'(1);
        rem_r   <= rem_r - gbn_pkg::SEQ_W'(1);
        first_r <= 1'b0;
      end
      if ((cmd.accept && !cmd.start_replay) || cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[next_r] <= in_data.payload;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[ptr_r];
    end
    if (cmd.accept && !cmd.start_replay) begin
      out_data_r <= result;
    end else if (cmd.emit) begin
      out_data_r.kind           <= gbn_pkg::KIND_SENT;
      out_data_r.seq_number     <= ptr_r;
      out_data_r.packet_payload <= rd_data_r;
      out_data_r.timer_action   <= first_r ? gbn_pkg::TIMER_RESTART : gbn_pkg::TIMER_LEAVE;
      out_data_r.last           <= (rem_r == gbn_pkg::SEQ_W'(1));
    end
  end

endmodule

[design/go_back_n_sender_window.sv]
// Top level of the go-back-n sender window.
// A result is registered at the edge that accepts its item; a replaying timeout gives none.
// Send, ack, unused and empty-window timeout commands run back to back unless the output stalls.
// A timeout with packets outstanding stalls input and replays each: memory read, then emit.
// Synchronous active-low reset clears the window pointers and sets the window size to 4.
// The payload memory is not cleared; only entries written by a send are read.
module go_back_n_sender_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gbn_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gbn_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gbn_pkg::SEQ_W-1:0] cfg_data
);

  gbn_pkg::gbn_cmd_t    cmd;
  gbn_pkg::gbn_status_t status;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
